FILE: rtl/ced_pkg.sv
`default_nettype none

package ced_pkg;

  // field widths fixed by the interface
  localparam int SAMPLE_W = 16;
  localparam int THR_W    = 31;
  localparam int TMO_W    = 16;
  localparam int SUM_W    = 43;
  localparam int SIL_W    = 16;
  localparam int RUN_W    = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 31;

  // square of a 16-bit magnitude never exceeds 2^30
  localparam int SQ_W = 31;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARMED     = 2'd2;

  // register reset values
  localparam logic [THR_W-1:0] THR_RESET   = 31'd1073742;
  localparam logic [TMO_W-1:0] TMO_RESET   = 16'd2000;
  localparam logic             ARMED_RESET = 1'b1;

  localparam logic [SIL_W-1:0] SIL_MAX = {SIL_W{1'b1}};
  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [TMO_W-1:0] timeout_ms;
    logic             armed;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] energy_sum;
    logic             loud;
    logic             speech_seen;
    logic [SIL_W-1:0] silence_ms;
    logic [RUN_W-1:0] loud_run;
    logic             stop;
  } res_t;

  typedef struct packed {
    logic wr;
    logic halted;
  } back_sts_t;

endpackage

`default_nettype wire

FILE: rtl/ced_fifo.sv
`default_nettype none

module ced_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [WIDTH-1:0]           wr_data,
  input  wire logic                       rd_en,
  output logic      [WIDTH-1:0]           rd_data,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    cnt_r;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign count   = cnt_r;

endmodule

`default_nettype wire

FILE: rtl/ced_front.sv
`default_nettype none

module ced_front #(
  parameter int MAX_CHUNK      = 4096,
  parameter int SAMPLES_PER_MS = 16,
  parameter int MDEPTH         = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire logic signed [ced_pkg::SAMPLE_W-1:0]   in_sample,
  input  wire logic                                  in_last_in_chunk,
  input  wire logic [$clog2(MDEPTH+1)-1:0]           mid_cnt,
  output logic                                       q_wr,
  output logic [30+$clog2(MAX_CHUNK+1)-1:0]          q_sum,
  output logic [$clog2(MAX_CHUNK+1)-1:0]             q_cnt,
  output logic [$clog2(MAX_CHUNK+1)-1:0]             q_ms
);
  import ced_pkg::*;

  localparam int CNT_W = $clog2(MAX_CHUNK + 1);
  localparam int ACC_W = 30 + CNT_W;
  localparam int SUB_W = (SAMPLES_PER_MS > 1) ? $clog2(SAMPLES_PER_MS) : 1;

  logic               accept;
  logic [SAMPLE_W-1:0] mag;
  logic [CNT_W-1:0]   cnt_inc;
  logic               sub_wrap;
  logic [CNT_W-1:0]   ms_inc;
  logic               chunk_end;

  logic [CNT_W-1:0]   cnt_r;
  logic [SUB_W-1:0]   sub_r;
  logic [CNT_W-1:0]   ms_r;
  logic               v1_r;
  logic               end1_r;
  logic [SQ_W-1:0]    sq1_r;
  logic [CNT_W-1:0]   cnt1_r;
  logic [CNT_W-1:0]   ms1_r;
  logic [ACC_W-1:0]   acc_r;

  // room check: queue fill plus a chunk end about to be written
  assign full   = (32'(mid_cnt) + 32'(q_wr)) >= 32'(MDEPTH);
  assign accept = push && !full;

  // sample magnitude, most negative value maps to 32768
  assign mag = in_sample[SAMPLE_W-1] ? (~in_sample + SAMPLE_W'(1)) : in_sample;

  // chunk bookkeeping for the incoming beat
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign sub_wrap  = (sub_r == SUB_W'(SAMPLES_PER_MS - 1));
  assign ms_inc    = ms_r + CNT_W'(sub_wrap);
  assign chunk_end = in_last_in_chunk || (cnt_inc == CNT_W'(MAX_CHUNK));

  // control: chunk counters, stage valid and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sub_r  <= '0;
      ms_r   <= '0;
      v1_r   <= 1'b0;
      end1_r <= 1'b0;
      acc_r  <= '0;
    end else begin
      v1_r <= accept;
      if (accept) begin
        end1_r <= chunk_end;
        if (chunk_end) begin
          cnt_r <= '0;
          sub_r <= '0;
          ms_r  <= '0;
        end else begin
          cnt_r <= cnt_inc;
          sub_r <= sub_wrap ? '0 : sub_r + SUB_W'(1);
          ms_r  <= ms_inc;
        end
      end
      if (v1_r) begin
        acc_r <= end1_r ? '0 : q_sum;
      end
    end
  end

  // square stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      sq1_r  <= SQ_W'(mag) * SQ_W'(mag);
      cnt1_r <= cnt_inc;
      ms1_r  <= ms_inc;
    end
  end

  // accumulate and hand finished chunks to the queue
  assign q_sum = acc_r + ACC_W'(sq1_r);
  assign q_wr  = v1_r && end1_r;
  assign q_cnt = cnt1_r;
  assign q_ms  = ms1_r;

endmodule

`default_nettype wire

FILE: rtl/ced_back.sv
`default_nettype none

module ced_back #(
  parameter int MAX_CHUNK = 4096,
  parameter int ODEPTH    = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire ced_pkg::cfg_t                       cfg,
  input  wire logic                                q_empty,
  output logic                                     q_rd,
  input  wire logic [30+$clog2(MAX_CHUNK+1)-1:0]   q_sum,
  input  wire logic [$clog2(MAX_CHUNK+1)-1:0]      q_cnt,
  input  wire logic [$clog2(MAX_CHUNK+1)-1:0]      q_ms,
  input  wire logic [$clog2(ODEPTH+1)-1:0]         out_cnt,
  output ced_pkg::res_t                            res,
  output ced_pkg::back_sts_t                       sts
);
  import ced_pkg::*;

  localparam int CNT_W  = $clog2(MAX_CHUNK + 1);
  localparam int ACC_W  = 30 + CNT_W;
  localparam int PROD_W = THR_W + CNT_W;
  localparam int ADD_W  = ((CNT_W > SIL_W) ? CNT_W : SIL_W) + 1;

  logic               pv_r;
  logic [ACC_W-1:0]   psum_r;
  logic [CNT_W-1:0]   pms_r;
  logic [PROD_W-1:0]  prod_r;

  logic               speech_r;
  logic [SIL_W-1:0]   sil_r;
  logic [RUN_W-1:0]   run_r;
  logic               halted_r;

  logic               speech_nxt;
  logic [SIL_W-1:0]   sil_nxt;
  logic [RUN_W-1:0]   run_nxt;
  logic               halted_nxt;
  logic               loud;
  logic               stop;
  logic               res_wr;
  logic [ADD_W-1:0]   sil_add;

  // take a chunk when the result queue is sure to have room
  assign q_rd = !q_empty && ((32'(out_cnt) + 32'(pv_r)) < 32'(ODEPTH));

  // product stage: threshold times sample count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= q_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      psum_r <= q_sum;
      pms_r  <= q_ms;
      prod_r <= PROD_W'(cfg.threshold) * PROD_W'(q_cnt);
    end
  end

  // decision stage: loudness and silence timing
  always_comb begin
    speech_nxt = speech_r;
    sil_nxt    = sil_r;
    run_nxt    = run_r;
    halted_nxt = halted_r;
    stop       = 1'b0;
    loud       = PROD_W'(psum_r) > prod_r;
    sil_add    = ADD_W'(sil_r) + ADD_W'(pms_r);
    res_wr     = pv_r && !halted_r;
    if (res_wr) begin
      if (loud) begin
        if (run_r != RUN_MAX) begin
          run_nxt = run_r + RUN_W'(1);
        end
        speech_nxt = 1'b1;
        sil_nxt    = '0;
      end else begin
        run_nxt = '0;
        if (cfg.armed && speech_r) begin
          sil_nxt = (sil_add > ADD_W'(SIL_MAX)) ? SIL_MAX : SIL_W'(sil_add);
          if (sil_nxt >= cfg.timeout_ms) begin
            stop       = 1'b1;
            halted_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speech_r <= 1'b0;
      sil_r    <= '0;
      run_r    <= '0;
      halted_r <= 1'b0;
    end else begin
      speech_r <= speech_nxt;
      sil_r    <= sil_nxt;
      run_r    <= run_nxt;
      halted_r <= halted_nxt;
    end
  end

  // result beat
  assign res.energy_sum  = SUM_W'(psum_r);
  assign res.loud        = loud;
  assign res.speech_seen = speech_nxt;
  assign res.silence_ms  = sil_nxt;
  assign res.loud_run    = run_nxt;
  assign res.stop        = stop;

  assign sts.wr     = res_wr;
  assign sts.halted = halted_r;

endmodule

`default_nettype wire

FILE: rtl/chunk_energy_silence_detector.sv
`default_nettype none

// Energy-based voice activity detector. Signed 16-bit samples stream in, one
// per clock, through push/full; a chunk closes on last_in_chunk or at its
// MAX_CHUNK-th sample, and each closed chunk yields one result through
// empty/pop with the exact sum of squares (units of 2^-30 full scale), the
// loud decision (sum > energy_threshold * count), and the speech, silence and
// loud-run state after it. Sustained rate is one sample per cycle while full
// is low. Samples are squared as accepted; a chunk's result then goes through
// accumulate into the chunk queue, threshold multiply and result queue write.
// full rises only when the four-entry queue between the accumulator and the
// decision logic is about to fill, which follows from pop being held low.
// Once stop is reported, further samples are still taken but produce no
// results until reset. Registers are written through cfg_we/cfg_addr/cfg_data
// and the user must do so only while idle; the block does not enforce it.
module chunk_energy_silence_detector #(
  parameter int MAX_CHUNK      = 4096,
  parameter int SAMPLES_PER_MS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic signed [ced_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                                in_last_in_chunk,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic [ced_pkg::SUM_W-1:0]                out_chunk_energy_sum,
  output logic                                     out_loud,
  output logic                                     out_speech_seen,
  output logic [ced_pkg::SIL_W-1:0]                out_silence_elapsed_ms,
  output logic [ced_pkg::RUN_W-1:0]                out_loud_run,
  output logic                                     out_stop,
  input  wire logic                                cfg_we,
  input  wire logic [ced_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  wire logic [ced_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import ced_pkg::*;

  localparam int CNT_W  = $clog2(MAX_CHUNK + 1);
  localparam int ACC_W  = 30 + CNT_W;
  localparam int MDEPTH = 4;
  localparam int ODEPTH = 4;
  localparam int MCW    = $clog2(MDEPTH + 1);
  localparam int OCW    = $clog2(ODEPTH + 1);
  localparam int MQ_W   = ACC_W + 2 * CNT_W;
  localparam int RES_W  = $bits(res_t);

  cfg_t              cfg_r;
  logic              q_wr;
  logic [ACC_W-1:0]  f_sum;
  logic [CNT_W-1:0]  f_cnt;
  logic [CNT_W-1:0]  f_ms;
  logic [MCW-1:0]    mid_cnt;
  logic [MQ_W-1:0]   mid_rd_data;
  logic              q_rd;
  logic [OCW-1:0]    out_cnt;
  res_t              res;
  res_t              head;
  back_sts_t         sts;
  logic              out_rd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold  <= THR_RESET;
      cfg_r.timeout_ms <= TMO_RESET;
      cfg_r.armed      <= ARMED_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_THRESHOLD: cfg_r.threshold  <= cfg_data[THR_W-1:0];
        REG_TIMEOUT:   cfg_r.timeout_ms <= cfg_data[TMO_W-1:0];
        REG_ARMED:     cfg_r.armed      <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // front: square and accumulate per chunk
  ced_front #(
    .MAX_CHUNK      (MAX_CHUNK),
    .SAMPLES_PER_MS (SAMPLES_PER_MS),
    .MDEPTH         (MDEPTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_sample        (in_sample),
    .in_last_in_chunk (in_last_in_chunk),
    .mid_cnt          (mid_cnt),
    .q_wr             (q_wr),
    .q_sum            (f_sum),
    .q_cnt            (f_cnt),
    .q_ms             (f_ms)
  );

  // chunk queue between front and back
  ced_fifo #(
    .WIDTH (MQ_W),
    .DEPTH (MDEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data ({f_sum, f_cnt, f_ms}),
    .rd_en   (q_rd),
    .rd_data (mid_rd_data),
    .count   (mid_cnt)
  );

  // back: threshold decision and silence timing
  ced_back #(
    .MAX_CHUNK (MAX_CHUNK),
    .ODEPTH    (ODEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (mid_cnt == '0),
    .q_rd    (q_rd),
    .q_sum   (mid_rd_data[MQ_W-1 -: ACC_W]),
    .q_cnt   (mid_rd_data[2*CNT_W-1 -: CNT_W]),
    .q_ms    (mid_rd_data[CNT_W-1:0]),
    .out_cnt (out_cnt),
    .res     (res),
    .sts     (sts)
  );

  // result queue
  ced_fifo #(
    .WIDTH (RES_W),
    .DEPTH (ODEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (sts.wr),
    .wr_data (res),
    .rd_en   (out_rd),
    .rd_data (head),
    .count   (out_cnt)
  );

  assign empty  = (out_cnt == '0);
  assign out_rd = pop && !empty;

  assign out_chunk_energy_sum   = head.energy_sum;
  assign out_loud               = head.loud;
  assign out_speech_seen        = head.speech_seen;
  assign out_silence_elapsed_ms = head.silence_ms;
  assign out_loud_run           = head.loud_run;
  assign out_stop               = head.stop;

  // queues never overflow
  a_mid_room: assert property (@(posedge clk) disable iff (!rst_n)
    32'(mid_cnt) <= 32'(MDEPTH))
    else $error("chunk queue overflow");

  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    sts.wr |-> 32'(out_cnt) < 32'(ODEPTH) || out_rd)
    else $error("result queue written while full");

  // nothing reported once stopped
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    sts.halted |-> !sts.wr)
    else $error("result after stop");

  // a loud chunk restarts silence and marks speech
  a_loud_state: assert property (@(posedge clk) disable iff (!rst_n)
    (sts.wr && res.loud) |-> (res.silence_ms == '0 && res.speech_seen && !res.stop))
    else $error("loud chunk state mismatch");

  // stop is followed by halt
  a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (sts.wr && res.stop) |=> sts.halted)
    else $error("stop did not halt");

endmodule

`default_nettype wire
